[design/bfid_pkg.sv]
// Shared types, constants and controller encodings for the box filter downscaler.
package bfid_pkg;

    // Fixed field widths.
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 4;
    localparam int SIZE_W     = 15;
    localparam int OSIZE_W    = 11;
    localparam int CNT_W      = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    // Largest source size that is honored; larger values are clamped to it.
    localparam logic [SIZE_W-1:0] SRC_LIMIT = 15'd16384;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_W = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_H = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_W = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_H = 2'd3;

    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
        logic [CH_W-1:0] alpha_in;
    } t_pixel;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
        logic [CH_W-1:0] alpha_out;
        logic            frame_end;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FACT,
        ST_FWAIT,
        ST_READ,
        ST_ACC,
        ST_DWAIT,
        ST_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic fact_start;
        logic fact_load;
        logic mem_read;
        logic accum;
        logic area_start;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_valid;
        logic frame_start;
        logic emit;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

[design/bfid_stream_if.sv]
// Valid/ready stream channel carrying one payload of a given type per beat.
interface bfid_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[design/bfid_div.sv]
// Multi-lane restoring divider, one quotient bit per lane per cycle.
module bfid_div #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 11,
    parameter int LANES = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [LANES-1:0][NUM_W-1:0] i_num,
    input  logic [LANES-1:0][DEN_W-1:0] i_den,
    output logic [LANES-1:0][NUM_W-1:0] o_quo,
    output logic                        o_done
);
    localparam int STEP_W = $clog2(NUM_W);

    logic [LANES-1:0][DEN_W-1:0] r_rem, n_rem;
    logic [LANES-1:0][NUM_W-1:0] r_quo, n_quo;
    logic [LANES-1:0][DEN_W-1:0] r_den;
    logic [STEP_W-1:0]           r_step;
    logic                        r_busy;
    logic                        r_done;

    // One shift-and-subtract step in every lane.
    always_comb begin
        logic [DEN_W:0] shifted;
        logic [DEN_W:0] diff;
        for (int l = 0; l < LANES; l++) begin
            shifted = {r_rem[l], r_quo[l][NUM_W-1]};
            diff    = shifted - {1'b0, r_den[l]};
            if (shifted >= {1'b0, r_den[l]}) begin
                n_rem[l] = diff[DEN_W-1:0];
                n_quo[l] = {r_quo[l][NUM_W-2:0], 1'b1};
            end else begin
                n_rem[l] = shifted[DEN_W-1:0];
                n_quo[l] = {r_quo[l][NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;
endmodule

[design/bfid_ctrl.sv]
// Controller state machine that sequences one source pixel at a time.
module bfid_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bfid_pkg::t_status i_st,
    output bfid_pkg::t_cmd    o_cmd
);
    import bfid_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_st.in_valid) begin
                    n_state = i_st.frame_start ? ST_FACT : ST_READ;
                end
            end
            ST_FACT:  n_state = ST_FWAIT;
            ST_FWAIT: begin
                if (i_st.div_done) begin
                    n_state = ST_READ;
                end
            end
            ST_READ:  n_state = ST_ACC;
            ST_ACC:   n_state = i_st.emit ? ST_DWAIT : ST_IDLE;
            ST_DWAIT: begin
                if (i_st.div_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_st.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE:  o_cmd.in_ready = 1'b1;
            ST_FACT:  o_cmd.fact_start = 1'b1;
            ST_FWAIT: o_cmd.fact_load = i_st.div_done;
            ST_READ:  o_cmd.mem_read = 1'b1;
            ST_ACC: begin
                o_cmd.accum      = 1'b1;
                o_cmd.area_start = i_st.emit;
            end
            ST_DWAIT: o_cmd = '0;
            ST_OUT:   o_cmd.out_load = i_st.out_free;
            default:  o_cmd = '0;
        endcase
    end
endmodule

[design/bfid_dp.sv]
// Datapath: configuration, position counters, column sum store, divider and output register.
module bfid_dp #(
    parameter int MAX_OUT_WIDTH = 1024,
    parameter int MAX_SCALE     = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [bfid_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bfid_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_pix_valid,
    input  bfid_pkg::t_pixel                   i_pix_data,
    input  logic                               i_res_ready,
    output logic                               o_res_valid,
    output bfid_pkg::t_result                  o_res_data,
    input  bfid_pkg::t_cmd                     i_cmd,
    output bfid_pkg::t_status                  o_st
);
    import bfid_pkg::*;

    localparam int FACT_W = $clog2(MAX_SCALE + 1);
    localparam int AREA_W = $clog2(MAX_SCALE * MAX_SCALE + 1);
    localparam int SUM_W  = $clog2(MAX_SCALE * MAX_SCALE * (2 ** CH_W - 1) + 1);
    localparam int NUM_W  = (SUM_W > SIZE_W) ? SUM_W : SIZE_W;
    localparam int DEN_W  = (AREA_W > OSIZE_W) ? AREA_W : OSIZE_W;
    localparam int ADDR_W = (MAX_OUT_WIDTH > 1) ? $clog2(MAX_OUT_WIDTH) : 1;
    localparam int PROD_W = CNT_W + 1 + FACT_W;

    // Configuration registers.
    logic [SIZE_W-1:0]  r_src_w, r_src_h;
    logic [OSIZE_W-1:0] r_out_w, r_out_h;

    // Position and factor state.
    logic [CNT_W-1:0]  r_col, r_row, r_bc, r_br;
    logic [CNT_W-1:0]  n_col, n_row, n_bc, n_br;
    logic [FACT_W-1:0] r_cib, r_rib, n_cib, n_rib;
    logic [FACT_W-1:0] r_sx, r_sy, n_sx, n_sy;
    logic [AREA_W-1:0] r_area;

    // Per-pixel working registers.
    t_pixel                          r_pix;
    logic [NUM_CH-1:0][SUM_W-1:0]    r_rd;
    logic [NUM_CH-1:0][SUM_W-1:0]    n_sum;
    logic [NUM_CH-1:0][CH_W-1:0]     px;
    logic [PROD_W-1:0]               r_cprod, r_rprod;
    logic                            r_fend;
    logic                            r_ovalid;
    t_result                         r_out;

    // Column sum store.
    logic [NUM_CH*SUM_W-1:0] r_mem [MAX_OUT_WIDTH];
    logic [ADDR_W-1:0]       addr;

    // Effective sizes.
    logic [SIZE_W-1:0]  sw, sh;
    logic [OSIZE_W-1:0] ow, oh;

    // Block tests.
    logic [CNT_W:0]   bc1, br1;
    logic [PROD_W:0]  cprod_next, rprod_next;
    logic             col_ok, row_ok, col_last, row_last;
    logic             in_range, is_first, blk_last, emit;

    // Divider lanes.
    logic                         div_start, div_done;
    logic [NUM_CH-1:0][NUM_W-1:0] div_num, div_quo;
    logic [NUM_CH-1:0][DEN_W-1:0] div_den;

    function automatic logic [FACT_W-1:0] clamp_fact(input logic [NUM_W-1:0] q);
        logic [FACT_W-1:0] f;
        if (q == '0) begin
            f = FACT_W'(1);
        end else if (q > NUM_W'(MAX_SCALE)) begin
            f = FACT_W'(MAX_SCALE);
        end else begin
            f = q[FACT_W-1:0];
        end
        return f;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= SIZE_W'(1);
            r_src_h <= SIZE_W'(1);
            r_out_w <= OSIZE_W'(1);
            r_out_h <= OSIZE_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SRC_W: r_src_w <= i_cfg_data;
                CFG_SRC_H: r_src_h <= i_cfg_data;
                CFG_OUT_W: r_out_w <= i_cfg_data[OSIZE_W-1:0];
                CFG_OUT_H: r_out_h <= i_cfg_data[OSIZE_W-1:0];
                default:   r_src_w <= r_src_w;
            endcase
        end
    end

    always_comb begin
        sw = (r_src_w == '0) ? SIZE_W'(1) : ((r_src_w > SRC_LIMIT) ? SRC_LIMIT : r_src_w);
        sh = (r_src_h == '0) ? SIZE_W'(1) : ((r_src_h > SRC_LIMIT) ? SRC_LIMIT : r_src_h);
        ow = (r_out_w == '0) ? OSIZE_W'(1) : r_out_w;
        oh = (r_out_h == '0) ? OSIZE_W'(1) : r_out_h;
    end

    assign px[0] = r_pix.red_in;
    assign px[1] = r_pix.green_in;
    assign px[2] = r_pix.blue_in;
    assign px[3] = r_pix.alpha_in;

    assign addr = r_bc[ADDR_W-1:0];
    assign bc1  = {1'b0, r_bc} + (CNT_W + 1)'(1);
    assign br1  = {1'b0, r_br} + (CNT_W + 1)'(1);

    // Range tests use (index + 1) * factor and last-block tests (index + 2) * factor against the source size.
    always_comb begin
        cprod_next = {1'b0, r_cprod} + (PROD_W + 1)'(r_sx);
        rprod_next = {1'b0, r_rprod} + (PROD_W + 1)'(r_sy);
        col_ok   = (bc1 <= (CNT_W + 1)'(ow)) && (r_cprod <= PROD_W'(sw))
                   && (bc1 <= (CNT_W + 1)'(MAX_OUT_WIDTH));
        row_ok   = (br1 <= (CNT_W + 1)'(oh)) && (r_rprod <= PROD_W'(sh));
        col_last = (bc1 >= (CNT_W + 1)'(ow)) || (cprod_next > (PROD_W + 1)'(sw))
                   || (bc1 >= (CNT_W + 1)'(MAX_OUT_WIDTH));
        row_last = (br1 >= (CNT_W + 1)'(oh)) || (rprod_next > (PROD_W + 1)'(sh));
        in_range = col_ok && row_ok;
        is_first = (r_cib == '0) && (r_rib == '0);
        blk_last = (r_cib == r_sx - 1'b1) && (r_rib == r_sy - 1'b1);
        emit     = in_range && blk_last;
        for (int c = 0; c < NUM_CH; c++) begin
            n_sum[c] = is_first ? SUM_W'(px[c]) : r_rd[c] + SUM_W'(px[c]);
        end
    end

    // Raster position step at the end of each pixel.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_bc  = r_bc;
        n_br  = r_br;
        n_cib = r_cib;
        n_rib = r_rib;
        if (({1'b0, r_col} + (CNT_W + 1)'(1)) >= (CNT_W + 1)'(sw)) begin
            n_col = '0;
            n_cib = '0;
            n_bc  = '0;
            if (({1'b0, r_row} + (CNT_W + 1)'(1)) >= (CNT_W + 1)'(sh)) begin
                n_row = '0;
                n_rib = '0;
                n_br  = '0;
            end else begin
                n_row = r_row + 1'b1;
                if (({1'b0, r_rib} + (FACT_W + 1)'(1)) >= {1'b0, r_sy}) begin
                    n_rib = '0;
                    n_br  = r_br + 1'b1;
                end else begin
                    n_rib = r_rib + 1'b1;
                end
            end
        end else begin
            n_col = r_col + 1'b1;
            if (({1'b0, r_cib} + (FACT_W + 1)'(1)) >= {1'b0, r_sx}) begin
                n_cib = '0;
                n_bc  = r_bc + 1'b1;
            end else begin
                n_cib = r_cib + 1'b1;
            end
        end
    end

    assign n_sx = clamp_fact(div_quo[0]);
    assign n_sy = clamp_fact(div_quo[1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_bc   <= '0;
            r_br   <= '0;
            r_cib  <= '0;
            r_rib  <= '0;
            r_sx   <= FACT_W'(1);
            r_sy   <= FACT_W'(1);
            r_area <= AREA_W'(1);
        end else begin
            if (i_cmd.fact_load) begin
                r_sx   <= n_sx;
                r_sy   <= n_sy;
                r_area <= AREA_W'(AREA_W'(n_sx) * AREA_W'(n_sy));
            end
            if (i_cmd.accum) begin
                r_col <= n_col;
                r_row <= n_row;
                r_bc  <= n_bc;
                r_br  <= n_br;
                r_cib <= n_cib;
                r_rib <= n_rib;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_ready && i_pix_valid) begin
            r_pix <= i_pix_data;
        end
        if (i_cmd.mem_read) begin
            r_cprod <= PROD_W'(bc1) * PROD_W'(r_sx);
            r_rprod <= PROD_W'(br1) * PROD_W'(r_sy);
        end
        if (i_cmd.accum) begin
            r_fend <= col_last && row_last;
        end
    end

    // Store write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accum && in_range) begin
            r_mem[addr] <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_read) begin
            r_rd <= r_mem[addr];
        end
    end

    // Lanes 0 and 1 find the factors at frame start; all four lanes find the block means.
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            if (i_cmd.fact_start) begin
                div_num[c] = '0;
                div_den[c] = DEN_W'(1);
            end else begin
                div_num[c] = NUM_W'(n_sum[c]);
                div_den[c] = DEN_W'(r_area);
            end
        end
        if (i_cmd.fact_start) begin
            div_num[0] = NUM_W'(sw);
            div_den[0] = DEN_W'(ow);
            div_num[1] = NUM_W'(sh);
            div_den[1] = DEN_W'(oh);
        end
    end

    assign div_start = i_cmd.fact_start || i_cmd.area_start;

    bfid_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W),
        .LANES (NUM_CH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quo   (div_quo),
        .o_done  (div_done)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_res_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.red_out   <= div_quo[0][CH_W-1:0];
            r_out.green_out <= div_quo[1][CH_W-1:0];
            r_out.blue_out  <= div_quo[2][CH_W-1:0];
            r_out.alpha_out <= div_quo[3][CH_W-1:0];
            r_out.frame_end <= r_fend;
        end
    end

    assign o_res_valid = r_ovalid;
    assign o_res_data  = r_out;

    assign o_st.in_valid    = i_pix_valid;
    assign o_st.frame_start = (r_col == '0) && (r_row == '0);
    assign o_st.emit        = emit;
    assign o_st.div_done    = div_done;
    assign o_st.out_free    = !r_ovalid || i_res_ready;
endmodule

[design/box_filter_image_downscale.sv]
// Top level of the integer box filter image downscaler.
//
//  Channel  Direction  Payload                                   Beat
//  i_pix    in         red_in, green_in, blue_in, alpha_in       one source pixel, raster order
//  o_res    out        red/green/blue/alpha_out, frame_end       one block mean
//  i_cfg    in         register index and write data             one register write
//
// A source pixel that completes no block passes through accept, store read and accumulate.
// A pixel that completes a block then waits for the four-lane serial divider (one quotient
// bit per cycle, NUM_W = 16 at MAX_SCALE = 16) and has its result loaded. The first pixel
// of a frame also waits for the same divider finding the scale factors.
// Reset is synchronous and active low; it clears the position counters, sets the factors and
// sizes to one and empties the output register. The column sum store needs no clearing.
// A stalled result sits in the output register; the next pixel is taken meanwhile and
// processing stops only when its own result must be loaded.
module box_filter_image_downscale #(
    parameter int MAX_OUT_WIDTH = 1024,
    parameter int MAX_SCALE     = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [bfid_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bfid_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bfid_stream_if.sink                     i_pix,
    bfid_stream_if.source                   o_res
);
    import bfid_pkg::*;

    // Commands and status between the sequencer and the datapath.
    t_cmd    cmd;
    t_status st;

    // The controller steps a pixel through factor setup, store read, accumulation,
    // division and result load.
    bfid_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    // The datapath holds the counters, the column sums and the output register.
    bfid_dp #(
        .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
        .MAX_SCALE     (MAX_SCALE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_pix_valid (i_pix.valid),
        .i_pix_data  (i_pix.data),
        .i_res_ready (o_res.ready),
        .o_res_valid (o_res.valid),
        .o_res_data  (o_res.data),
        .i_cmd       (cmd),
        .o_st        (st)
    );

    // Input is ready only while the sequencer waits for a pixel.
    assign i_pix.ready = cmd.in_ready;

    // Input is never ready in the cycle after a pixel is accepted.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pix.valid && i_pix.ready) |=> !i_pix.ready)
        else $error("input accepted on back-to-back cycles");

    // The divider is never started for factors and for block means at once, and no
    // result is loaded in the same cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.fact_start, cmd.area_start, cmd.out_load}))
        else $error("conflicting divider and output commands");

    // A result is loaded only into a free output register.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_res.valid || o_res.ready))
        else $error("result overwrote a pending beat");
endmodule

[test/testbench.sv]
// Self-checking testbench for the box filter image downscaler, with its own block-mean predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bfid_pkg::*;

    // The instance is built with the default line store and scale limit, and the predictor
    // uses the same two numbers.
    localparam int          LINE_COLS     = 1024;
    localparam int          SCALE_CAP     = 16;
    // Worst case for a pixel that ends no block is the frame-start factor division plus the
    // store read and accumulate; SETTLE_CYCLES leaves margin before a register write.
    localparam int unsigned SETTLE_CYCLES = 64;
    localparam int unsigned CYCLE_LIMIT   = 800000;
    localparam int unsigned RANDOM_PIXELS = 80;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bfid_stream_if #(.T(t_pixel))  pix_if ();
    bfid_stream_if #(.T(t_result)) res_if ();

    box_filter_image_downscale #(
        .MAX_OUT_WIDTH (LINE_COLS),
        .MAX_SCALE     (SCALE_CAP)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_if),
        .o_res      (res_if)
    );

    // Shadow copy of the size registers, as the block holds them after masking.
    logic [SIZE_W-1:0]  shadow_src_w;
    logic [SIZE_W-1:0]  shadow_src_h;
    logic [OSIZE_W-1:0] shadow_out_w;
    logic [OSIZE_W-1:0] shadow_out_h;

    // Predictor state: raster position, latched factors, row within the current block row
    // and the per-column channel sums of the line store.
    int unsigned pos_col;
    int unsigned pos_row;
    int unsigned fac_h;
    int unsigned fac_v;
    int unsigned row_phase;
    int unsigned col_sum [LINE_COLS][NUM_CH];

    // Block means that the block still owes us, oldest first.
    t_result     pending_means [$];

    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;

    // Pacing controls shared between the tests, the pixel sender and the result sink.
    bit          send_pace;
    bit          recv_pace;
    int unsigned hold_request;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // A source size of zero counts as one, and anything above the honored limit is clamped.
    function automatic int unsigned src_dim(input int unsigned v);
        if (v == 0) return 1;
        if (v > 32'(SRC_LIMIT)) return 32'(SRC_LIMIT);
        return v;
    endfunction

    function automatic int unsigned out_dim(input int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    // The reduction factor of one axis, held to 1..SCALE_CAP.
    function automatic int unsigned block_factor(input int unsigned src, input int unsigned dst);
        int unsigned f;
        f = src / dst;
        if (f < 1) f = 1;
        if (f > SCALE_CAP) f = SCALE_CAP;
        return f;
    endfunction

    // Advances the predictor by one accepted source pixel. When the pixel is the last one of
    // a block that lies inside the output image, the block mean is queued.
    function automatic void fold_pixel(input t_pixel px);
        int unsigned sw;
        int unsigned sh;
        int unsigned cols;
        int unsigned rows;
        int unsigned blk_col;
        int unsigned blk_row;
        int unsigned col_phase;
        int unsigned area;
        int unsigned chan [NUM_CH];
        t_result     mean;

        chan[0] = 32'(px.red_in);
        chan[1] = 32'(px.green_in);
        chan[2] = 32'(px.blue_in);
        chan[3] = 32'(px.alpha_in);
        sw = src_dim(32'(shadow_src_w));
        sh = src_dim(32'(shadow_src_h));

        // Factors are latched on the first pixel of a frame only; sizes stay live.
        if (pos_col == 0 && pos_row == 0) begin
            fac_h     = block_factor(sw, out_dim(32'(shadow_out_w)));
            fac_v     = block_factor(sh, out_dim(32'(shadow_out_h)));
            row_phase = 0;
        end

        cols = out_dim(32'(shadow_out_w));
        if (sw / fac_h < cols) cols = sw / fac_h;
        if (LINE_COLS < cols) cols = LINE_COLS;
        rows = out_dim(32'(shadow_out_h));
        if (sh / fac_v < rows) rows = sh / fac_v;

        blk_col   = pos_col / fac_h;
        col_phase = pos_col % fac_h;
        blk_row   = pos_row / fac_v;

        if (blk_col < cols && blk_row < rows) begin
            for (int c = 0; c < NUM_CH; c++) begin
                if (col_phase == 0 && row_phase == 0) begin
                    col_sum[blk_col][c] = chan[c];
                end else begin
                    col_sum[blk_col][c] = col_sum[blk_col][c] + chan[c];
                end
            end
            if (col_phase == fac_h - 1 && row_phase == fac_v - 1) begin
                area            = fac_h * fac_v;
                mean.red_out    = CH_W'(col_sum[blk_col][0] / area);
                mean.green_out  = CH_W'(col_sum[blk_col][1] / area);
                mean.blue_out   = CH_W'(col_sum[blk_col][2] / area);
                mean.alpha_out  = CH_W'(col_sum[blk_col][3] / area);
                mean.frame_end  = (blk_col == cols - 1 && blk_row == rows - 1);
                pending_means.push_back(mean);
            end
        end

        // Counters that sit at or past a size that shrank wrap at the end of their line.
        if (pos_col + 1 >= sw) begin
            pos_col = 0;
            if (pos_row + 1 >= sh) begin
                pos_row   = 0;
                row_phase = 0;
            end else begin
                pos_row   = pos_row + 1;
                row_phase = (row_phase + 1 >= fac_v) ? 0 : row_phase + 1;
            end
        end else begin
            pos_col = pos_col + 1;
        end
    endfunction

    // Offers one pixel, after a random gap while send pacing is on, and returns at the edge where it is taken.
    task automatic send_pixel(input t_pixel px);
        int unsigned gap;
        gap = send_pace ? $urandom_range(0, 19) : 0;
        if (gap != 0) begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_if.valid <= 1'b1;
        pix_if.data  <= px;
        do @(posedge i_clk); while (!pix_if.ready);
        fold_pixel(px);
    endtask

    task automatic send_random_pixels(input int unsigned count);
        repeat (count) send_pixel(t_pixel'($urandom));
    endtask

    // Stops offering pixels, waits for every owed mean and then lets the pipeline go quiet,
    // since the last pixels may have produced nothing yet still be in flight.
    task automatic wait_drained();
        pix_if.valid <= 1'b0;
        while (pending_means.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write; the caller lowers the write enable after the last one.
    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            CFG_SRC_W: shadow_src_w = val;
            CFG_SRC_H: shadow_src_h = val;
            CFG_OUT_W: shadow_out_w = val[OSIZE_W-1:0];
            CFG_OUT_H: shadow_out_h = val[OSIZE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_sizes(input int unsigned sw, input int unsigned sh,
                             input int unsigned ow, input int unsigned oh);
        wait_drained();
        put_reg(CFG_SRC_W, CFG_DATA_W'(sw));
        put_reg(CFG_SRC_H, CFG_DATA_W'(sh));
        put_reg(CFG_OUT_W, CFG_DATA_W'(ow));
        put_reg(CFG_OUT_H, CFG_DATA_W'(oh));
        i_cfg_we <= 1'b0;
    endtask

    // Brings the raster position back to a frame start from anywhere: with a 1x1 source the
    // next pixel closes both the line and the frame, and it can only touch column 0 of row 0.
    task automatic restart_frame();
        set_sizes(1, 1, 1, 1);
        send_pixel(t_pixel'($urandom));
    endtask

    // Out of reset every size is one, so each pixel is a whole frame and comes straight back.
    task automatic test_power_on_sizes();
        send_pixel(32'h0000_0000);
        send_pixel(32'hFFFF_FFFF);
        send_pixel(t_pixel'($urandom));
    endtask

    // Zero in every size register is taken as one.
    task automatic test_zero_sizes();
        set_sizes(0, 0, 0, 0);
        send_random_pixels(2);
    endtask

    // Two 2x2 blocks: one saturated, one whose sums do not divide evenly.
    task automatic test_block_means();
        set_sizes(4, 2, 2, 1);
        for (int i = 0; i < 8; i++) begin
            if (i % 4 < 2) send_pixel(32'hFFFF_FFFF);
            else if (i < 4) send_pixel(32'h00FF_01FE);
            else send_pixel(32'hFF00_0001);
        end
    endtask

    // A 7x5 source with 2x2 blocks leaves a column and a row that belong to no block.
    task automatic test_partial_blocks();
        set_sizes(7, 5, 3, 2);
        send_random_pixels(35);
    endtask

    // Quotients above the scale limit are clamped, first across and then down.
    task automatic test_factor_clamp();
        set_sizes(20, 1, 1, 1);
        send_random_pixels(20);
        set_sizes(1, 20, 1, 1);
        send_random_pixels(20);
    endtask

    // A single 16x16 block, mostly saturated, drives the channel sums to their widest.
    task automatic test_max_area();
        set_sizes(16, 16, 1, 1);
        repeat (256) begin
            if ($urandom_range(0, 3) != 0) send_pixel(32'hFFFF_FFFF);
            else send_pixel(t_pixel'($urandom));
        end
    endtask

    // All-ones source width is clamped to the honored limit, which gives a factor of 8 against
    // the widest output; the output registers also see data bits above their width. Only the
    // start of the huge first line is sent before the position is brought back.
    task automatic test_oversized_source();
        set_sizes(15'h7FFF, 0, 15'h7FFF, 0);
        send_random_pixels(24);
        restart_frame();
    endtask

    // Sizes changed in the middle of a frame. The width shrinks while the column counter is
    // already past it, so that line wraps early; then the height shrinks below the current
    // row, so the frame ends at the end of that line and a new one latches new factors.
    task automatic test_live_resize();
        set_sizes(8, 4, 2, 2);
        send_random_pixels(7);
        set_sizes(4, 4, 2, 2);
        send_random_pixels(5);
        set_sizes(4, 2, 2, 2);
        send_random_pixels(3);
        send_random_pixels(8);
    endtask

    // The receiver holds off for a long stretch while pixels keep coming at full rate, so
    // the output register fills and the input stalls. Then the sender waits for every mean
    // before it starts again.
    task automatic test_backpressure();
        set_sizes(16, 2, 16, 2);
        send_pace    = 1'b0;
        recv_pace    = 1'b0;
        hold_request = 300;
        send_random_pixels(32);
        wait_drained();
        send_pace = 1'b1;
        recv_pace = 1'b1;
        send_random_pixels(32);
    endtask

    // Mostly whole frames of random geometry with random content. Some frames use large
    // factors or zero sizes, and some are cut short and followed by a restart.
    task automatic test_random_frames();
        int unsigned sent;
        int unsigned kind;
        int unsigned sw;
        int unsigned sh;
        int unsigned ow;
        int unsigned oh;
        int unsigned len;
        int unsigned cut;
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                ow = $urandom_range(1, 4);
                sw = $urandom_range(ow, 4 * ow + 3);
                oh = $urandom_range(1, 3);
                sh = $urandom_range(oh, 3 * oh + 2);
            end else if (kind < 9) begin
                ow = $urandom_range(1, 2);
                sw = $urandom_range(16, 36);
                oh = 1;
                sh = $urandom_range(1, 4);
            end else begin
                ow = $urandom_range(0, 3);
                sw = $urandom_range(0, 5);
                oh = $urandom_range(0, 3);
                sh = $urandom_range(0, 5);
            end
            set_sizes(sw, sh, ow, oh);
            send_pace = ($urandom_range(0, 3) != 0);
            recv_pace = ($urandom_range(0, 3) != 0);
            len = src_dim(sw) * src_dim(sh);
            if (len > 1 && $urandom_range(0, 5) == 0) begin
                cut = $urandom_range(1, len - 1);
                send_random_pixels(cut);
                restart_frame();
                sent = sent + cut + 1;
            end else begin
                send_random_pixels(len);
                sent = sent + len;
            end
        end
    endtask

    // Result side: draws a stall per beat while pacing is on, or takes a long hold when a test asks.
    initial begin : result_sink
        int unsigned stall;
        res_if.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = recv_pace ? $urandom_range(0, 19) : 0;
            if (hold_request != 0) begin
                stall        = hold_request;
                hold_request = 0;
            end
            if (stall != 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
        end
    end

    task automatic compare_field(input string name, input logic [CH_W-1:0] want,
                                 input logic [CH_W-1:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Every result beat is matched against the oldest owed mean.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_means.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, got %p", $time, res_if.data);
                mismatches++;
            end else begin
                want = pending_means.pop_front();
                compare_field("red_out", want.red_out, res_if.data.red_out);
                compare_field("green_out", want.green_out, res_if.data.green_out);
                compare_field("blue_out", want.blue_out, res_if.data.blue_out);
                compare_field("alpha_out", want.alpha_out, res_if.data.alpha_out);
                compare_field("frame_end", CH_W'(want.frame_end),
                              CH_W'(res_if.data.frame_end));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_SRC_W;
        i_cfg_data   <= '0;
        pix_if.valid <= 1'b0;
        pix_if.data  <= '0;
        send_pace    = 1'b1;
        recv_pace    = 1'b1;
        hold_request = 0;

        // The predictor starts from the reset state of the block.
        shadow_src_w = SIZE_W'(1);
        shadow_src_h = SIZE_W'(1);
        shadow_out_w = OSIZE_W'(1);
        shadow_out_h = OSIZE_W'(1);
        pos_col      = 0;
        pos_row      = 0;
        fac_h        = 1;
        fac_v        = 1;
        row_phase    = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_power_on_sizes();
        test_zero_sizes();
        test_block_means();
        test_partial_blocks();
        test_factor_clamp();
        test_oversized_source();
        test_live_resize();
        test_max_area();
        test_backpressure();
        test_random_frames();

        wait_drained();
        if (mismatches == 0 && pending_means.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
